/* rtl/u8scc_pkg.sv */
`timescale 1ns / 1ps

package u8scc_pkg;

  localparam int DataW            = 8;
  localparam int OutW             = 16;
  localparam int RemW             = 3;
  localparam int CountBitsDefault = 16;

  // Lead byte class boundaries
  localparam logic [DataW-1:0] ContMask  = 8'hC0;
  localparam logic [DataW-1:0] ContTag   = 8'h80;
  localparam logic [DataW-1:0] Lead2Min  = 8'hC0;
  localparam logic [DataW-1:0] Lead3Min  = 8'hE0;
  localparam logic [DataW-1:0] Lead4Min  = 8'hF0;
  localparam logic [DataW-1:0] Lead5Min  = 8'hF8;
  localparam logic [DataW-1:0] Lead6Min  = 8'hFC;
  localparam logic [DataW-1:0] BadLead   = 8'hFF;

  typedef struct packed {
    logic            is_zero;   // string terminator
    logic            is_cont;   // matches 10xxxxxx
    logic            lead_ok;   // usable as a lead byte
    logic            is_ascii;  // single-byte symbol
    logic [RemW-1:0] rem;       // continuation bytes that follow this lead
  } byte_info_t;

endpackage

/* rtl/u8scc_decode.sv */
`timescale 1ns / 1ps

module u8scc_decode
  import u8scc_pkg::*;
(
  input  logic [DataW-1:0] data_byte_i,
  output byte_info_t       info_o
);

  always_comb begin
    info_o          = '0;
    info_o.is_zero  = (data_byte_i == '0);
    info_o.is_cont  = ((data_byte_i & ContMask) == ContTag);
    case (data_byte_i) inside
      [8'h00 : ContTag - 8'h01]: begin
        info_o.lead_ok  = 1'b1;
        info_o.is_ascii = 1'b1;
        info_o.rem      = RemW'(0);
      end
      [Lead2Min : Lead3Min - 8'h01]: begin
        info_o.lead_ok = 1'b1;
        info_o.rem     = RemW'(1);
      end
      [Lead3Min : Lead4Min - 8'h01]: begin
        info_o.lead_ok = 1'b1;
        info_o.rem     = RemW'(2);
      end
      [Lead4Min : Lead5Min - 8'h01]: begin
        info_o.lead_ok = 1'b1;
        info_o.rem     = RemW'(3);
      end
      [Lead5Min : Lead6Min - 8'h01]: begin
        info_o.lead_ok = 1'b1;
        info_o.rem     = RemW'(4);
      end
      [Lead6Min : BadLead - 8'h01]: begin
        info_o.lead_ok = 1'b1;
        info_o.rem     = RemW'(5);
      end
      default: begin
        // continuation byte or 0xFF in lead position
        info_o.lead_ok = 1'b0;
      end
    endcase
  end

endmodule

/* rtl/u8scc_track.sv */
`timescale 1ns / 1ps

module u8scc_track
  import u8scc_pkg::*;
#(
  parameter int COUNT_BITS = CountBitsDefault
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  step_i,
  input  byte_info_t            info_i,
  output logic                  ok_o,
  output logic [COUNT_BITS-1:0] symbols_o,
  output logic [COUNT_BITS-1:0] width_o,
  output logic [COUNT_BITS-1:0] multibyte_o
);

  localparam logic [COUNT_BITS-1:0] CntMax = '1;

  logic [RemW-1:0]       rem_q, rem_d;
  logic                  lead_err_q, lead_err_d;
  logic                  cont_err_q, cont_err_d;
  logic [COUNT_BITS-1:0] sym_q, sym_d;
  logic [COUNT_BITS-1:0] wid_q, wid_d;
  logic [COUNT_BITS-1:0] mb_q, mb_d;

  always_comb begin
    rem_d      = rem_q;
    lead_err_d = lead_err_q;
    cont_err_d = cont_err_q;
    sym_d      = sym_q;
    wid_d      = wid_q;
    mb_d       = mb_q;
    if (step_i) begin
      if (info_i.is_zero) begin
        rem_d      = '0;
        lead_err_d = 1'b0;
        cont_err_d = 1'b0;
        sym_d      = '0;
        wid_d      = '0;
        mb_d       = '0;
      end else if (lead_err_q) begin
        // rest of the string is skipped
      end else if (rem_q != '0) begin
        if (!info_i.is_cont) begin
          cont_err_d = 1'b1;
        end
        rem_d = rem_q - RemW'(1);
      end else if (!info_i.lead_ok) begin
        lead_err_d = 1'b1;
      end else begin
        sym_d = (sym_q == CntMax) ? CntMax : sym_q + COUNT_BITS'(1);
        if (info_i.is_ascii) begin
          wid_d = (wid_q == CntMax) ? CntMax : wid_q + COUNT_BITS'(1);
        end else begin
          wid_d = (wid_q >= CntMax - COUNT_BITS'(1)) ? CntMax : wid_q + COUNT_BITS'(2);
          mb_d  = (mb_q == CntMax) ? CntMax : mb_q + COUNT_BITS'(1);
        end
        rem_d = info_i.rem;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q      <= '0;
      lead_err_q <= 1'b0;
      cont_err_q <= 1'b0;
      sym_q      <= '0;
      wid_q      <= '0;
      mb_q       <= '0;
    end else begin
      rem_q      <= rem_d;
      lead_err_q <= lead_err_d;
      cont_err_q <= cont_err_d;
      sym_q      <= sym_d;
      wid_q      <= wid_d;
      mb_q       <= mb_d;
    end
  end

  // Summary of the string so far, taken when the terminator is consumed
  assign ok_o        = !lead_err_q && !cont_err_q && (rem_q == '0);
  assign symbols_o   = lead_err_q ? '0 : sym_q;
  assign width_o     = lead_err_q ? '0 : wid_q;
  assign multibyte_o = lead_err_q ? '0 : mb_q;

endmodule

/* rtl/utf8_string_checker_counter_unit.sv */
`timescale 1ns / 1ps
// Channel  | Signals                                   | Transaction when
// ---------+-------------------------------------------+-----------------------------
// input    | in_valid_i, in_stall_o, data_byte_i        | in_valid_i && !in_stall_o
// output   | out_valid_o, out_stall_i, is_valid_o,      | out_valid_o && !out_stall_i
//          | symbol_count_o, display_width_o,           |
//          | multibyte_count_o                          |
//
// One byte per cycle sustained while no terminator is held. A byte is registered
// in the input register and decoded into the tracking state; a zero byte loads
// the result register, from which the result is shown.
// Only a terminator waiting on a full, stalled result register holds the input.
// Reset clears the tracking state and both valid flags; no clearing pass.

module utf8_string_checker_counter_unit
  import u8scc_pkg::*;
#(
  parameter int COUNT_BITS = CountBitsDefault
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic [DataW-1:0] data_byte_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic             is_valid_o,
  output logic [OutW-1:0]  symbol_count_o,
  output logic [OutW-1:0]  display_width_o,
  output logic [OutW-1:0]  multibyte_count_o
);

  logic             in_vld_q;
  logic [DataW-1:0] byte_q;
  byte_info_t       info;
  logic             out_free;
  logic             step;
  logic             emit;

  logic                  ok;
  logic [COUNT_BITS-1:0] sym_cnt;
  logic [COUNT_BITS-1:0] wid_cnt;
  logic [COUNT_BITS-1:0] mb_cnt;
  logic [OutW-1:0]       sym_ext;
  logic [OutW-1:0]       wid_ext;
  logic [OutW-1:0]       mb_ext;

  logic            out_vld_q;
  logic            ok_q;
  logic [OutW-1:0] sym_q;
  logic [OutW-1:0] wid_q;
  logic [OutW-1:0] mb_q;

  u8scc_decode u_decode (
    .data_byte_i (byte_q),
    .info_o      (info)
  );

  assign out_free   = !out_vld_q || !out_stall_i;
  assign step       = in_vld_q && (!info.is_zero || out_free);
  assign emit       = step && info.is_zero;
  assign in_stall_o = in_vld_q && !step;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      byte_q <= data_byte_i;
    end
  end

  u8scc_track #(
    .COUNT_BITS (COUNT_BITS)
  ) u_track (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (step),
    .info_i      (info),
    .ok_o        (ok),
    .symbols_o   (sym_cnt),
    .width_o     (wid_cnt),
    .multibyte_o (mb_cnt)
  );

  // Reported counts are the low bits of the counters
  if (COUNT_BITS >= OutW) begin : g_trunc
    assign sym_ext = sym_cnt[OutW-1:0];
    assign wid_ext = wid_cnt[OutW-1:0];
    assign mb_ext  = mb_cnt[OutW-1:0];
  end else begin : g_ext
    assign sym_ext = OutW'(sym_cnt);
    assign wid_ext = OutW'(wid_cnt);
    assign mb_ext  = OutW'(mb_cnt);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (emit) begin
      out_vld_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      ok_q  <= ok;
      sym_q <= sym_ext;
      wid_q <= wid_ext;
      mb_q  <= mb_ext;
    end
  end

  assign out_valid_o       = out_vld_q;
  assign is_valid_o        = ok_q;
  assign symbol_count_o    = sym_q;
  assign display_width_o   = wid_q;
  assign multibyte_count_o = mb_q;

endmodule

/* rtl/u8scc_checker.sv */
`timescale 1ns / 1ps

module u8scc_checker
  import u8scc_pkg::*;
#(
  parameter int COUNT_BITS = CountBitsDefault
) (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             in_valid_i,
  input logic             in_stall_o,
  input logic [DataW-1:0] data_byte_i,
  input logic             out_valid_o,
  input logic             out_stall_i,
  input logic             is_valid_o,
  input logic [OutW-1:0]  symbol_count_o,
  input logic [OutW-1:0]  display_width_o,
  input logic [OutW-1:0]  multibyte_count_o
);

  // Count relations only hold when no high counter bits are cut off
  localparam bit          Exact  = (COUNT_BITS <= OutW);
  localparam int          MaxW   = (COUNT_BITS < OutW) ? COUNT_BITS : OutW;
  localparam logic [OutW:0] CntMax = (OutW + 1)'((64'd1 << MaxW) - 64'd1);

  logic [OutW:0] sum_ext;
  assign sum_ext = {1'b0, symbol_count_o} + {1'b0, multibyte_count_o};

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(is_valid_o)
      && $stable(symbol_count_o) && $stable(display_width_o)
      && $stable(multibyte_count_o))
    else $error("result changed while stalled");

  a_no_idle_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!out_valid_o || !out_stall_i) |-> !in_stall_o)
    else $error("input stalled while the result register can take a result");

  a_mb_le_sym: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && Exact |-> multibyte_count_o <= symbol_count_o)
    else $error("multibyte count exceeds symbol count");

  a_width_sum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && Exact && ({1'b0, display_width_o} != CntMax)
      |-> {1'b0, display_width_o} == sum_ext)
    else $error("display width differs from symbols plus multibyte symbols");

  logic unused_in;
  assign unused_in = in_valid_i ^ (^data_byte_i);

endmodule

bind utf8_string_checker_counter_unit u8scc_checker #(
  .COUNT_BITS (COUNT_BITS)
) u_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .in_valid_i        (in_valid_i),
  .in_stall_o        (in_stall_o),
  .data_byte_i       (data_byte_i),
  .out_valid_o       (out_valid_o),
  .out_stall_i       (out_stall_i),
  .is_valid_o        (is_valid_o),
  .symbol_count_o    (symbol_count_o),
  .display_width_o   (display_width_o),
  .multibyte_count_o (multibyte_count_o)
);

/* tb/testbench.sv */
`timescale 1ns / 1ps

module testbench;
  import u8scc_pkg::*;

  localparam int          CountBits  = CountBitsDefault;
  localparam int unsigned CycleLimit = 1_000_000;
  localparam int unsigned TailCycles = 8;

  typedef enum {FaultNone, FaultLead, FaultCont, FaultTrunc, FaultNoise} fault_e;

  typedef struct packed {
    logic [DataW-1:0] value;
    logic             drain;  // hold this byte back until no result is outstanding
  } pend_t;

  typedef struct packed {
    logic            ok;
    logic [OutW-1:0] symbols;
    logic [OutW-1:0] width;
    logic [OutW-1:0] multi;
  } tally_t;

  logic             clk_i       = 1'b0;
  logic             rst_ni      = 1'b0;
  logic             in_valid    = 1'b0;
  logic [DataW-1:0] data_byte   = '0;
  logic             out_stall   = 1'b0;
  logic             in_stall_o;
  logic             out_valid_o;
  logic             is_valid_o;
  logic [OutW-1:0]  symbol_count_o;
  logic [OutW-1:0]  display_width_o;
  logic [OutW-1:0]  multibyte_count_o;

  pend_t            byte_q[$];
  tally_t           tally_q[$];
  int unsigned      idle_pct   = 0;
  int unsigned      stall_pct  = 0;
  int unsigned      err_count  = 0;
  int unsigned      cycle_cnt  = 0;
  bit               byte_taken = 1'b0;

  // decoder tracking state
  logic [2:0]       cont_left;
  bit               bad_lead;
  bit               bad_cont;
  bit [63:0]        sym_cnt;
  bit [63:0]        wid_cnt;
  bit [63:0]        mb_cnt;

  utf8_string_checker_counter_unit #(
    .COUNT_BITS(CountBits)
  ) i_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid),
    .in_stall_o       (in_stall_o),
    .data_byte_i      (data_byte),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall),
    .is_valid_o       (is_valid_o),
    .symbol_count_o   (symbol_count_o),
    .display_width_o  (display_width_o),
    .multibyte_count_o(multibyte_count_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt >= CycleLimit) begin
      $display("FAIL utf8_string_checker_counter_unit");
      $finish;
    end
  end

  task automatic note_error(input string msg);
    $display("ERROR @%0t: %s", $realtime, msg);
    err_count++;
  endtask

  function automatic bit [63:0] sat_inc(input bit [63:0] cnt, input int unsigned step);
    bit [63:0] cap;
    bit [63:0] sum;
    cap = (64'd1 << CountBits) - 64'd1;
    sum = cnt + step;
    return (sum > cap) ? cap : sum;
  endfunction

  function automatic int unsigned symbol_len(input logic [DataW-1:0] b);
    if (b < ContTag)  return 1;
    if (b < Lead2Min) return 0;
    if (b < Lead3Min) return 2;
    if (b < Lead4Min) return 3;
    if (b < Lead5Min) return 4;
    if (b < Lead6Min) return 5;
    if (b < BadLead)  return 6;
    return 0;
  endfunction

  task automatic clear_tracking();
    cont_left = '0;
    bad_lead  = 1'b0;
    bad_cont  = 1'b0;
    sym_cnt   = '0;
    wid_cnt   = '0;
    mb_cnt    = '0;
  endtask

  // Advance the decoder by one accepted byte; a terminator queues the summary.
  task automatic track_byte(input logic [DataW-1:0] b);
    tally_t      res;
    int unsigned len;
    if (b == '0) begin
      res.ok      = !bad_lead && !bad_cont && (cont_left == '0);
      res.symbols = bad_lead ? '0 : sym_cnt[OutW-1:0];
      res.width   = bad_lead ? '0 : wid_cnt[OutW-1:0];
      res.multi   = bad_lead ? '0 : mb_cnt[OutW-1:0];
      tally_q.push_back(res);
      clear_tracking();
    end else if (bad_lead) begin
      // everything up to the terminator is ignored
    end else if (cont_left != '0) begin
      if ((b & ContMask) != ContTag) bad_cont = 1'b1;
      cont_left = cont_left - 3'd1;
    end else begin
      len = symbol_len(b);
      if (len == 0) begin
        bad_lead = 1'b1;
      end else begin
        sym_cnt   = sat_inc(sym_cnt, 1);
        wid_cnt   = sat_inc(wid_cnt, (len == 1) ? 1 : 2);
        if (len != 1) mb_cnt = sat_inc(mb_cnt, 1);
        cont_left = 3'(len - 1);
      end
    end
  endtask

  task automatic put_byte(input logic [DataW-1:0] b);
    pend_t item;
    item.value = b;
    item.drain = ($urandom_range(99) < 2);
    byte_q.push_back(item);
  endtask

  function automatic logic [DataW-1:0] lead_for(input int unsigned len);
    case (len)
      2:       return DataW'($urandom_range(Lead2Min, Lead3Min - 1));
      3:       return DataW'($urandom_range(Lead3Min, Lead4Min - 1));
      4:       return DataW'($urandom_range(Lead4Min, Lead5Min - 1));
      5:       return DataW'($urandom_range(Lead5Min, Lead6Min - 1));
      default: return DataW'($urandom_range(Lead6Min, BadLead - 1));
    endcase
  endfunction

  function automatic logic [DataW-1:0] cont_byte();
    return DataW'($urandom_range(ContTag, Lead2Min - 1));
  endfunction

  // Mostly well-formed strings with random content; some carry one fault.
  task automatic queue_strings(input int unsigned byte_budget);
    int unsigned sent;
    int unsigned n_sym;
    int unsigned fault_at;
    int unsigned len;
    int unsigned cut;
    fault_e      fault;
    bit          cut_off;
    sent = 0;
    while (sent < byte_budget) begin
      case ($urandom_range(9))
        0:       fault = FaultLead;
        1:       fault = FaultCont;
        2:       fault = FaultTrunc;
        3:       fault = FaultNoise;
        default: fault = FaultNone;
      endcase
      n_sym = $urandom_range(6);
      if (fault != FaultNone && n_sym == 0) n_sym = 1;
      fault_at = (n_sym == 0) ? 0 : $urandom_range(n_sym - 1);
      cut_off  = 1'b0;
      if (fault == FaultNoise) begin
        repeat ($urandom_range(1, 12)) begin
          put_byte(DataW'($urandom_range(1, 255)));
          sent++;
        end
      end else begin
        for (int i = 0; i < n_sym && !cut_off; i++) begin
          len = ($urandom_range(1)) ? 1 : $urandom_range(2, 6);
          if (i == fault_at && (fault == FaultCont || fault == FaultTrunc) && len == 1)
            len = $urandom_range(2, 6);
          if (i == fault_at && fault == FaultLead) begin
            put_byte($urandom_range(1) ? BadLead : cont_byte());
            sent++;
          end
          if (len == 1) begin
            put_byte(DataW'($urandom_range(1, ContTag - 1)));
            sent++;
          end else begin
            put_byte(lead_for(len));
            sent++;
            cut = $urandom_range(1, len - 1);
            for (int k = 1; k < len; k++) begin
              if (i == fault_at && fault == FaultTrunc && k == cut) begin
                cut_off = 1'b1;
                break;
              end
              if (i == fault_at && fault == FaultCont && k == cut)
                put_byte($urandom_range(1) ? DataW'($urandom_range(1, ContTag - 1))
                                           : DataW'($urandom_range(Lead2Min, BadLead)));
              else
                put_byte(cont_byte());
              sent++;
            end
          end
        end
      end
      put_byte('0);
      sent++;
    end
  endtask

  task automatic queue_list(input logic [DataW-1:0] bytes[]);
    foreach (bytes[i]) put_byte(bytes[i]);
  endtask

  task automatic wait_idle();
    while (byte_q.size() != 0 || in_valid || tally_q.size() != 0) @(posedge clk_i);
  endtask

  // Inputs change on the falling edge; a byte stays put until taken.
  always @(negedge clk_i) begin : drive_in
    logic             nxt_valid;
    logic [DataW-1:0] nxt_data;
    pend_t            item;
    if (!rst_ni) begin
      in_valid  <= 1'b0;
      data_byte <= '0;
      out_stall <= 1'b0;
    end else begin
      nxt_valid = in_valid;
      nxt_data  = data_byte;
      if (!in_valid || byte_taken) begin
        nxt_valid = 1'b0;
        if (byte_q.size() != 0 && $urandom_range(99) >= idle_pct &&
            !(byte_q[0].drain && tally_q.size() != 0)) begin
          item      = byte_q.pop_front();
          nxt_valid = 1'b1;
          nxt_data  = item.value;
        end
      end
      in_valid  <= nxt_valid;
      data_byte <= nxt_data;
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  always @(posedge clk_i) begin : watch
    tally_t want;
    if (!rst_ni) begin
      byte_taken = 1'b0;
    end else begin
      if (out_valid_o && !out_stall) begin
        if (tally_q.size() == 0) begin
          note_error("result with no string pending");
        end else begin
          want = tally_q.pop_front();
          if (is_valid_o !== want.ok)
            note_error($sformatf("is_valid got %0b want %0b", is_valid_o, want.ok));
          if (symbol_count_o !== want.symbols)
            note_error($sformatf("symbol_count got %0d want %0d",
                                 symbol_count_o, want.symbols));
          if (display_width_o !== want.width)
            note_error($sformatf("display_width got %0d want %0d",
                                 display_width_o, want.width));
          if (multibyte_count_o !== want.multi)
            note_error($sformatf("multibyte_count got %0d want %0d",
                                 multibyte_count_o, want.multi));
        end
      end
      byte_taken = in_valid && !in_stall_o;
      if (byte_taken) track_byte(data_byte);
    end
  end

  initial begin
    clear_tracking();
    idle_pct  = 8;
    stall_pct = 46;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // empty string, ASCII and two-byte extremes
    queue_list('{8'h00, 8'h7F, 8'h01, 8'hC0, 8'h80, 8'h00});
    // three- to six-byte symbols at their lead bounds
    queue_list('{8'hE0, 8'hBF, 8'h80, 8'hF7, 8'h80, 8'h80, 8'h80, 8'h00});
    queue_list('{8'hFB, 8'h80, 8'h80, 8'h80, 8'h80,
                 8'hFE, 8'hBF, 8'hBF, 8'hBF, 8'hBF, 8'hBF, 8'h00});
    // bad lead (rest ignored), 0xFF lead, bad continuation, truncated symbol
    queue_list('{8'h41, 8'h80, 8'h41, 8'h00, 8'hFF, 8'h00});
    queue_list('{8'hC2, 8'h41, 8'h00, 8'hE2, 8'h82, 8'h00});
    queue_strings(200);
    wait_idle();

    idle_pct  = 46;
    stall_pct = 8;
    byte_q.push_back('{value: 8'h00, drain: 1'b1});
    queue_strings(200);
    wait_idle();

    idle_pct  = 0;
    stall_pct = 0;
    queue_strings(200);
    wait_idle();

    repeat (TailCycles) @(posedge clk_i);
    if (err_count == 0)
      $display("PASS utf8_string_checker_counter_unit");
    else
      $display("FAIL utf8_string_checker_counter_unit");
    $finish;
  end

endmodule
